// ===== sv/stack_arena_allocator_defines.svh =====
// Assertion macros used by the checker file of the stack arena allocator.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef STACK_ARENA_ALLOCATOR_DEFINES_SVH
`define STACK_ARENA_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SAA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define SAA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== sv/saa_pkg.sv =====
// Shared types and constants of the stack arena allocator.
// No dependencies; used by the top level and the port checker.
package saa_pkg;

    // Default configuration
    localparam int ARENA_MAX_BYTES_DEF    = 4096;
    localparam int LENGTH_FIELD_BYTES_DEF = 8;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int LEN_W    = 12;
    localparam int OFF_W    = 12;
    localparam int STAT_W   = 2;
    localparam int CFG_W    = 13;
    localparam int NTOP_W   = 13;
    localparam int FOOTER_W = LEN_W + 1;
    localparam int USED_BIT = LEN_W;

    localparam logic [CFG_W-1:0] ARENA_RESET = 13'd4096;

    // Request kinds
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAN = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_POP_RD,
        ST_POP_EVAL
    } state_t;

endpackage

// ===== sv/saa_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module saa_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/stack_arena_allocator.sv =====
// Stack arena allocator: top register, footer RAM and request sequencer.
// Depends on saa_pkg and saa_ram.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_ready | op, block_length, block_offset
//  out     | out_valid/out_ready | status, granted_offset, new_top
//  cfg     | cfg_valid/cfg_ready | cfg_data (arena size in bytes)
//
// Alloc, clean, unknown op, refused: result registered in the cycle after accept.
// Free: read-modify-write clears the used bit of the flag footer (skipped if the
// flag byte lies past the store), then the walk pops each freed block under the
// top (footer read, then evaluation) until the top is zero or its block is in use.
// Reset clears top and sequencer state; the footer RAM is not cleared.
// A new request is taken only in idle with the result register empty or draining.
module stack_arena_allocator #(
    parameter int ARENA_MAX_BYTES    = saa_pkg::ARENA_MAX_BYTES_DEF,
    parameter int LENGTH_FIELD_BYTES = saa_pkg::LENGTH_FIELD_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [saa_pkg::OP_W-1:0]    op,
    input  logic [saa_pkg::LEN_W-1:0]   block_length,
    input  logic [saa_pkg::OFF_W-1:0]   block_offset,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [saa_pkg::STAT_W-1:0]  status,
    output logic [saa_pkg::OFF_W-1:0]   granted_offset,
    output logic [saa_pkg::NTOP_W-1:0]  new_top,
    // configuration channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [saa_pkg::CFG_W-1:0]   cfg_data
);
    import saa_pkg::*;

    // AW indexes the footer RAM, TW holds top in 0..max, SW fits every sum
    localparam int AW = $clog2(ARENA_MAX_BYTES);
    localparam int TW = $clog2(ARENA_MAX_BYTES + 1);
    localparam int SW = ((TW > CFG_W) ? TW : CFG_W) + 2;

    localparam logic [SW-1:0] MAX_S = SW'(ARENA_MAX_BYTES);
    localparam logic [SW-1:0] FTR_S = SW'(LENGTH_FIELD_BYTES);
    localparam logic [SW-1:0] ONE_S = SW'(1);

    state_t              state_reg, state_next;
    logic [TW-1:0]       top_reg, top_next;
    logic [CFG_W-1:0]    arena_reg;
    logic [AW-1:0]       flag_reg, flag_next;
    logic                out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [OFF_W-1:0]    granted_reg, granted_next;
    logic [NTOP_W-1:0]   new_top_reg, new_top_next;

    // footer RAM port
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [FOOTER_W-1:0] ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [FOOTER_W-1:0] ram_rdata;

    logic [SW-1:0] arena_s, top_s, need_s, flag_s, span_s;
    logic          accept;

    // effective arena size, clamped to the RAM depth
    assign arena_s = (SW'(arena_reg) > MAX_S) ? MAX_S : SW'(arena_reg);
    assign top_s   = SW'(top_reg);
    // block + length field + flag byte
    assign need_s  = top_s + SW'(block_length) + FTR_S + ONE_S;
    // flag byte of the block being freed
    assign flag_s  = SW'(block_offset) + SW'(block_length) + FTR_S;
    // bytes popped for the footer under the top
    assign span_s  = SW'(ram_rdata[LEN_W-1:0]) + FTR_S + ONE_S;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign granted_offset = granted_reg;
    assign new_top        = new_top_reg;

    saa_ram #(
        .WIDTH (FOOTER_W),
        .DEPTH (ARENA_MAX_BYTES)
    ) u_footer_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_reg       <= '0;
            arena_reg     <= ARENA_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                arena_reg <= cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        flag_reg    <= flag_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        new_top_reg <= new_top_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        granted_next   = granted_reg;
        new_top_next   = new_top_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_ALLOC:
                        begin
                            out_valid_next = 1'b1;
                            if (need_s > arena_s)
                            begin
                                status_next  = STAT_FULL;
                                granted_next = '0;
                                new_top_next = NTOP_W'(top_reg);
                            end
                            else
                            begin
                                // footer flag byte sits at need - 1
                                ram_we       = 1'b1;
                                ram_waddr    = AW'(need_s - ONE_S);
                                ram_wdata    = {1'b1, block_length};
                                top_next     = TW'(need_s);
                                status_next  = STAT_DONE;
                                granted_next = OFF_W'(top_reg);
                                new_top_next = NTOP_W'(need_s);
                            end
                        end
                        OP_FREE:
                        begin
                            if (SW'(block_offset) >= arena_s)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = STAT_RANGE;
                                granted_next   = '0;
                                new_top_next   = NTOP_W'(top_reg);
                            end
                            else if (flag_s < MAX_S)
                            begin
                                // read the footer, clear its used bit next cycle
                                ram_raddr  = AW'(flag_s);
                                flag_next  = AW'(flag_s);
                                state_next = ST_RMW;
                            end
                            else
                            begin
                                // flag beyond the store: no write, still pop
                                state_next = ST_POP_RD;
                            end
                        end
                        OP_CLEAN:
                        begin
                            top_next       = '0;
                            out_valid_next = 1'b1;
                            status_next    = STAT_DONE;
                            granted_next   = '0;
                            new_top_next   = '0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            status_next    = STAT_DONE;
                            granted_next   = '0;
                            new_top_next   = NTOP_W'(top_reg);
                        end
                    endcase
                end
            end
            ST_RMW:
            begin
                // write back with used bit cleared; the pop read follows in
                // ST_POP_RD, so it always sees this write
                ram_we     = 1'b1;
                ram_waddr  = flag_reg;
                ram_wdata  = {1'b0, ram_rdata[LEN_W-1:0]};
                state_next = ST_POP_RD;
            end
            ST_POP_RD:
            begin
                if ((top_reg != '0) && (top_s <= MAX_S))
                begin
                    ram_raddr  = AW'(top_s - ONE_S);
                    state_next = ST_POP_EVAL;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    status_next    = STAT_DONE;
                    granted_next   = '0;
                    new_top_next   = NTOP_W'(top_reg);
                    state_next     = ST_IDLE;
                end
            end
            ST_POP_EVAL:
            begin
                if (ram_rdata[USED_BIT])
                begin
                    // block under the top still in use: walk ends
                    out_valid_next = 1'b1;
                    status_next    = STAT_DONE;
                    granted_next   = '0;
                    new_top_next   = NTOP_W'(top_reg);
                    state_next     = ST_IDLE;
                end
                else
                begin
                    // pop it; saturate at zero on underflow
                    if (span_s >= top_s)
                    begin
                        top_next = '0;
                    end
                    else
                    begin
                        top_next = TW'(top_s - span_s);
                    end
                    state_next = ST_POP_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/saa_checker.sv =====
// Port-level checker for the stack arena allocator, bound to the top level.
// Depends on saa_pkg and stack_arena_allocator_defines.svh.
`include "stack_arena_allocator_defines.svh"

module saa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [saa_pkg::STAT_W-1:0]  status,
    input logic [saa_pkg::OFF_W-1:0]   granted_offset,
    input logic [saa_pkg::NTOP_W-1:0]  new_top
);
    import saa_pkg::*;

    // a stalled result holds its payload
    `SAA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(granted_offset) && $stable(new_top))

    // no new request while a finished result is stuck
    `SAA_ASSERT_IMPL(a_no_accept_on_stall, out_valid && !out_ready, !in_ready)

    // refused allocation grants nothing
    `SAA_ASSERT_IMPL(a_full_no_grant, out_valid && (status == STAT_FULL), granted_offset == '0)

    // out-of-range free grants nothing
    `SAA_ASSERT_IMPL(a_range_no_grant, out_valid && (status == STAT_RANGE), granted_offset == '0)

endmodule

bind stack_arena_allocator saa_checker u_saa_checker (.*);

// ===== dv/stack_arena_allocator_test.sv =====
// Self-checking test of the stack arena allocator: directed corner requests, then random
// alloc/free/clean traffic with random idle on both channels and arena size changes.
// Depends on saa_pkg and the stack_arena_allocator RTL.

typedef struct packed {
    logic [saa_pkg::STAT_W-1:0] status;
    logic [saa_pkg::OFF_W-1:0]  granted;
    logic [saa_pkg::NTOP_W-1:0] top;
} arena_result_t;

// Tracks the arena (top, footers, size register) and the results still owed by the DUT.
class arena_ledger;
    localparam int ARENA_MAX = saa_pkg::ARENA_MAX_BYTES_DEF;
    localparam int FOOT      = saa_pkg::LENGTH_FIELD_BYTES_DEF + 1;

    logic [saa_pkg::CFG_W-1:0]    arena_cfg;
    int                           top;
    logic [saa_pkg::FOOTER_W-1:0] footer [0:ARENA_MAX-1];
    bit                           written [0:ARENA_MAX-1];
    int                           written_addrs[$];
    int                           live_off[$];
    int                           live_len[$];
    arena_result_t                pending_results[$];
    int                           errors;

    function new();
        arena_cfg = saa_pkg::ARENA_RESET;
        top       = 0;
        errors    = 0;
    endfunction

    function int arena_size();
        return (int'(arena_cfg) > ARENA_MAX) ? ARENA_MAX : int'(arena_cfg);
    endfunction

    function void set_arena(logic [saa_pkg::CFG_W-1:0] value);
        arena_cfg = value;
    endfunction

    // Walk footers down from the top; every block on the stack, freed or not.
    function void find_live();
        int addr;
        int len;
        live_off.delete();
        live_len.delete();
        addr = top;
        while (addr > 0) begin
            len  = int'(footer[addr-1][saa_pkg::LEN_W-1:0]);
            addr = addr - len - FOOT;
            if (addr < 0)
                break;
            live_off.push_back(addr);
            live_len.push_back(len);
        end
    endfunction

    function void note_request(logic [saa_pkg::OP_W-1:0] op, logic [saa_pkg::LEN_W-1:0] len,
                               logic [saa_pkg::OFF_W-1:0] off);
        arena_result_t res;
        int            arena;
        int            need;
        int            flag;
        int            span;
        arena       = arena_size();
        res.status  = saa_pkg::STAT_DONE;
        res.granted = '0;
        case (op)
            saa_pkg::OP_ALLOC:
            begin
                need = top + int'(len) + FOOT;
                if (need > arena)
                    res.status = saa_pkg::STAT_FULL;
                else
                begin
                    res.granted       = top[saa_pkg::OFF_W-1:0];
                    footer[need-1]    = {1'b1, len};
                    if (!written[need-1])
                    begin
                        written[need-1] = 1'b1;
                        written_addrs.push_back(need - 1);
                    end
                    top = need;
                end
            end
            saa_pkg::OP_FREE:
            begin
                if (int'(off) >= arena)
                    res.status = saa_pkg::STAT_RANGE;
                else
                begin
                    // flag byte sits after the length field; dropped past the store
                    flag = int'(off) + int'(len) + FOOT - 1;
                    if (flag < ARENA_MAX)
                        footer[flag][saa_pkg::USED_BIT] = 1'b0;
                    while (top > 0 && !footer[top-1][saa_pkg::USED_BIT])
                    begin
                        span = int'(footer[top-1][saa_pkg::LEN_W-1:0]) + FOOT;
                        top  = (span >= top) ? 0 : top - span;
                    end
                end
            end
            saa_pkg::OP_CLEAN:
                top = 0;
            default:
                ;
        endcase
        res.top = top[saa_pkg::NTOP_W-1:0];
        pending_results.push_back(res);
    endfunction

    function void check_result(logic [saa_pkg::STAT_W-1:0] status,
                               logic [saa_pkg::OFF_W-1:0] granted,
                               logic [saa_pkg::NTOP_W-1:0] new_top);
        arena_result_t exp;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result: status %0d granted_offset %0d new_top %0d",
                     $time, status, granted, new_top);
            errors++;
            return;
        end
        exp = pending_results.pop_front();
        if (status !== exp.status)
        begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time, exp.status, status);
            errors++;
        end
        if (granted !== exp.granted)
        begin
            $display("%0t: granted_offset mismatch: expected %0d, actual %0d",
                     $time, exp.granted, granted);
            errors++;
        end
        if (new_top !== exp.top)
        begin
            $display("%0t: new_top mismatch: expected %0d, actual %0d", $time, exp.top, new_top);
            errors++;
        end
    endfunction
endclass

module stack_arena_allocator_test;
    import saa_pkg::*;

    // op 3 has no name in the package; the block must treat it as a no-op
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int ARENA_MAX = ARENA_MAX_BYTES_DEF;
    localparam int FOOT      = LENGTH_FIELD_BYTES_DEF + 1;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [OP_W-1:0]   op;
    logic [LEN_W-1:0]  block_length;
    logic [OFF_W-1:0]  block_offset;
    logic              out_valid;
    logic              out_ready;
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  granted_offset;
    logic [NTOP_W-1:0] new_top;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;

    arena_ledger ledger = new();
    int          item_count = 0;
    logic        calm = 1'b0;   // no idling on either side while set

    stack_arena_allocator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .block_length   (block_length),
        .block_offset   (block_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .granted_offset (granted_offset),
        .new_top        (new_top),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Everything is driven right after the rising edge, so DUT outputs and our inputs
    // are settled at the falling edge. Handshakes are judged there: what is seen at the
    // falling edge is exactly what the next rising edge will act on.
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 12);

    always @(negedge clk)
        if (rst_n && out_valid && out_ready)
            ledger.check_result(status, granted_offset, new_top);

    // Hold the request until taken, then maybe idle at random while calm is clear. Valid
    // is left high when not idling so back-to-back requests see no bubble.
    task automatic send_request(input logic [OP_W-1:0] op_v, input logic [LEN_W-1:0] len_v,
                                input logic [OFF_W-1:0] off_v);
        in_valid     <= 1'b1;
        op           <= op_v;
        block_length <= len_v;
        block_offset <= off_v;
        do
            @(negedge clk);
        while (!in_ready);
        ledger.note_request(op_v, len_v, off_v);
        @(posedge clk);
        item_count++;
        calm <= (item_count >= 400 && item_count < 520);
        while (!calm && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Drop valid, let every owed result come out, then idle before returning.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (ledger.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_arena_size(input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_ready);
        ledger.set_arena(value);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed traffic: allocs and frees of blocks really on the stack.
    // The footer RAM is never cleared, so every free whose flag byte lands inside the
    // store must hit an address some alloc has written; the pop walk only ever reads
    // footers the stack itself put there.
    task automatic pick_request(output logic [OP_W-1:0] op_v, output logic [LEN_W-1:0] len_v,
                                output logic [OFF_W-1:0] off_v);
        int r;
        int k;
        int w;
        int lo;
        int arena;
        r     = $urandom_range(0, 99);
        arena = ledger.arena_size();
        off_v = OFF_W'($urandom);
        len_v = LEN_W'($urandom);
        if (r >= 45 && r < 80)
        begin
            ledger.find_live();
            if (ledger.live_off.size() == 0)
                r = 0;
        end
        if (r >= 86 && r < 90 && ledger.written_addrs.size() == 0)
            r = 0;
        if (r < 45)
        begin
            op_v = OP_ALLOC;
            k    = $urandom_range(0, 9);
            if (k < 7)
                len_v = LEN_W'($urandom_range(0, 127));
            else if (k < 9)
                len_v = LEN_W'($urandom_range(0, 1023));
        end
        else if (r < 80)
        begin
            op_v  = OP_FREE;
            k     = $urandom_range(0, ledger.live_off.size() - 1);
            off_v = OFF_W'(ledger.live_off[k]);
            len_v = LEN_W'(ledger.live_len[k]);
        end
        else if (r < 86)
            op_v = OP_CLEAN;
        else if (r < 90)
        begin
            // wrong length: flag byte lands on some previously written footer
            op_v  = OP_FREE;
            w     = ledger.written_addrs[$urandom_range(0, ledger.written_addrs.size() - 1)];
            lo    = w - (FOOT - 1) - 4095;
            if (lo < 0)
                lo = 0;
            off_v = OFF_W'($urandom_range(lo, w - (FOOT - 1)));
            len_v = LEN_W'(w - (FOOT - 1) - int'(off_v));
        end
        else if (r < 94 || (r < 97 && arena >= ARENA_MAX))
        begin
            // flag byte past the end of the footer store
            op_v = OP_FREE;
            lo   = ARENA_MAX - (FOOT - 1) - int'(off_v);
            if (lo < 0)
                lo = 0;
            len_v = LEN_W'($urandom_range(lo, 4095));
        end
        else if (r < 97)
        begin
            op_v  = OP_FREE;
            off_v = OFF_W'($urandom_range(arena, 4095));
        end
        else
            op_v = OP_UNUSED;
    endtask

    task automatic run_random(input int count);
        logic [OP_W-1:0]  o;
        logic [LEN_W-1:0] l;
        logic [OFF_W-1:0] f;
        repeat (count)
        begin
            pick_request(o, l, f);
            send_request(o, l, f);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        op           <= OP_ALLOC;
        block_length <= '0;
        block_offset <= '0;
        out_ready    <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Full-size arena: grants, refusal, free from the middle, cascaded pop,
        // dropped flag write, unknown op, clean, a block filling the arena exactly
        // and a pop that lands exactly on zero.
        write_arena_size(13'd4096);
        send_request(OP_ALLOC, 12'd0, 12'd4095);
        send_request(OP_ALLOC, 12'd4095, 12'd0);
        send_request(OP_ALLOC, 12'd100, 12'd0);
        send_request(OP_ALLOC, 12'd50, 12'd0);
        send_request(OP_FREE, 12'd100, 12'd9);
        send_request(OP_FREE, 12'd50, 12'd118);
        send_request(OP_FREE, 12'd4095, 12'd4095);
        send_request(OP_UNUSED, 12'd4095, 12'd4095);
        send_request(OP_CLEAN, 12'd4095, 12'd4095);
        send_request(OP_FREE, 12'd0, 12'd0);
        send_request(OP_ALLOC, 12'd4087, 12'd0);
        send_request(OP_ALLOC, 12'd0, 12'd0);
        send_request(OP_FREE, 12'd4087, 12'd0);
        wait_drained();

        // Smallest arena: one empty block fits, free offset at the arena edge is refused.
        write_arena_size(13'd10);
        send_request(OP_ALLOC, 12'd0, 12'd0);
        send_request(OP_ALLOC, 12'd1, 12'd0);
        send_request(OP_FREE, 12'd0, 12'd10);
        send_request(OP_FREE, 12'd0, 12'd0);
        send_request(OP_ALLOC, 12'd1, 12'd0);
        send_request(OP_CLEAN, 12'd0, 12'd0);
        wait_drained();

        // Register above the maximum clamps to the full arena.
        write_arena_size(13'd8191);
        send_request(OP_ALLOC, 12'd4087, 12'd0);
        send_request(OP_CLEAN, 12'd0, 12'd0);
        wait_drained();

        write_arena_size(13'd4096);
        run_random(250);
        write_arena_size(13'd8191);
        run_random(200);
        write_arena_size(CFG_W'($urandom_range(200, 4095)));
        run_random(200);
        write_arena_size(CFG_W'($urandom_range(10, 40)));
        run_random(50);
        write_arena_size(13'd4096);
        run_random(100);

        if (ledger.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+sv
sv/saa_pkg.sv
sv/saa_ram.sv
sv/stack_arena_allocator.sv
sv/saa_checker.sv
dv/stack_arena_allocator_test.sv
